// ----- hdl/bed_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bed_pkg
// Shared widths, codes and saturation helpers of the bandpass envelope
// decimator.
// ----------------------------------------------------------------------------
package bed_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int COEF_W      = 32;
   localparam int COEF_FRAC   = 30;
   localparam int STATE_W     = 48;
   localparam int DECIM_W     = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int BSUM_W      = COEF_W + 2;
   localparam int PROD_W      = COEF_W + SAMPLE_W;
   localparam int ACC_W       = STATE_W + 2;

   localparam logic signed [BSUM_W-1:0] COEF_ONE   = BSUM_W'(64'd1 << COEF_FRAC);
   localparam logic signed [ACC_W-1:0]  ROUND_HALF = ACC_W'(64'd1 << (COEF_FRAC - 1));

   localparam logic signed [ACC_W-1:0] SAMPLE_MAX_W = ACC_W'((64'd1 << (SAMPLE_W - 1)) - 1);
   localparam logic signed [ACC_W-1:0] SAMPLE_MIN_W = -SAMPLE_MAX_W - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] STATE_MAX_W  = ACC_W'((64'd1 << (STATE_W - 1)) - 1);
   localparam logic signed [ACC_W-1:0] STATE_MIN_W  = -STATE_MAX_W - ACC_W'(1);

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = SAMPLE_MAX_W[SAMPLE_W-1:0];
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = SAMPLE_MIN_W[SAMPLE_W-1:0];

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HP_A1,
      CSR_HP_A2,
      CSR_BL_A1,
      CSR_BL_A2,
      CSR_SM_A1,
      CSR_SM_A2,
      CSR_DECIM
   } csr_index_type;

   typedef enum logic [1:0] {
      SEC_HP,
      SEC_BL,
      SEC_SM
   } sec_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_COEF,
      ST_MUL_BX,
      ST_ACC,
      ST_MUL_A1,
      ST_Z1,
      ST_MUL_A2,
      ST_Z2,
      ST_DONE
   } state_type;

   function automatic logic signed [ACC_W-1:0] ext_acc(input logic signed [PROD_W-1:0] v);
      return {{(ACC_W-PROD_W){v[PROD_W-1]}}, v};
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sat_sample(
      input logic signed [ACC_W-1:0] v);
      if (v > SAMPLE_MAX_W) begin
         return SAMPLE_MAX;
      end else if (v < SAMPLE_MIN_W) begin
         return SAMPLE_MIN;
      end
      return v[SAMPLE_W-1:0];
   endfunction

   function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [ACC_W-1:0] v);
      if (v > STATE_MAX_W) begin
         return STATE_MAX_W[STATE_W-1:0];
      end else if (v < STATE_MIN_W) begin
         return STATE_MIN_W[STATE_W-1:0];
      end
      return v[STATE_W-1:0];
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] rectify(input logic signed [SAMPLE_W-1:0] v);
      if (v == SAMPLE_MIN) begin
         return SAMPLE_MAX;
      end else if (v < 0) begin
         return -v;
      end
      return v;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/bandpass_envelope_decimator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bandpass_envelope_decimator
// Highpass and lowpass biquads, full-wave rectifier, envelope lowpass biquad
// and output decimation over one shared multiplier.
// ----------------------------------------------------------------------------
// After acceptance, req_tready stays low while each of the three sections
// runs a seven-step sequence on the single 32x16 multiplier (numerator,
// b0*x, output, a1*y, z1, a2*y, z2); a final step then counts the sample,
// hands off every decimation-th result and stalls only while an earlier one
// still waits. The envelope value of every decimation-th sample is held in an
// output register, so a new sample is taken while an earlier result waits on rsp_tready.
module bandpass_envelope_decimator (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // req_tdata: sample[15:0]
   input  wire logic [bed_pkg::SAMPLE_W-1:0]        req_tdata,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // rsp_tdata: envelope[15:0]
   output logic [bed_pkg::SAMPLE_W-1:0]             rsp_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [bed_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [bed_pkg::COEF_W-1:0]          csr_data
);

   bed_pkg::state_type                       state_ff, state_in;
   bed_pkg::sec_type                         sec_ff, sec_in;
   logic signed [bed_pkg::COEF_W-1:0]        a1_ff [3], a1_in [3];
   logic signed [bed_pkg::COEF_W-1:0]        a2_ff [3], a2_in [3];
   logic signed [bed_pkg::STATE_W-1:0]       z1_ff [3], z1_in [3];
   logic signed [bed_pkg::STATE_W-1:0]       z2_ff [3], z2_in [3];
   logic [bed_pkg::DECIM_W-1:0]              decim_ff, decim_in;
   logic [bed_pkg::DECIM_W-1:0]              count_ff, count_in;
   logic                                     rsp_valid_ff, rsp_valid_in;
   logic signed [bed_pkg::SAMPLE_W-1:0]      rsp_data_ff, rsp_data_in;
   logic signed [bed_pkg::SAMPLE_W-1:0]      x_ff, x_in;
   logic signed [bed_pkg::SAMPLE_W-1:0]      y_ff, y_in;
   logic signed [bed_pkg::COEF_W-1:0]        b0_ff, b0_in;
   logic signed [bed_pkg::PROD_W-1:0]        prod_ff, prod_in;
   logic signed [bed_pkg::PROD_W-1:0]        bx_ff, bx_in;

   logic signed [bed_pkg::COEF_W-1:0]        a1_sel, a2_sel, mul_a;
   logic signed [bed_pkg::STATE_W-1:0]       z1_sel, z2_sel, z1_new, z2_new;
   logic signed [bed_pkg::SAMPLE_W-1:0]      mul_b;
   logic signed [bed_pkg::BSUM_W-1:0]        bsum, a1_ext, a2_ext;
   logic signed [bed_pkg::ACC_W-1:0]         acc, bx2, t1;
   logic [bed_pkg::DECIM_W-1:0]              decim_m;
   logic                                     emit;
   logic [1:0]                               si;

   assign req_tready = (state_ff == bed_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      case (sec_ff)
         bed_pkg::SEC_HP: si = 2'd0;
         bed_pkg::SEC_BL: si = 2'd1;
         default:         si = 2'd2;
      endcase
   end

   always_comb begin
      a1_sel = a1_ff[si];
      a2_sel = a2_ff[si];
      z1_sel = z1_ff[si];
      z2_sel = z2_ff[si];
      a1_ext = {{2{a1_sel[bed_pkg::COEF_W-1]}}, a1_sel};
      a2_ext = {{2{a2_sel[bed_pkg::COEF_W-1]}}, a2_sel};
      if (sec_ff == bed_pkg::SEC_HP) begin
         bsum = bed_pkg::COEF_ONE - a1_ext + a2_ext;
      end else begin
         bsum = bed_pkg::COEF_ONE + a1_ext + a2_ext;
      end

      case (state_ff)
         bed_pkg::ST_MUL_A1: mul_a = a1_sel;
         bed_pkg::ST_MUL_A2: mul_a = a2_sel;
         default:            mul_a = b0_ff;
      endcase
      mul_b   = (state_ff == bed_pkg::ST_MUL_BX) ? x_ff : y_ff;
      prod_in = mul_a * mul_b;

      acc = bed_pkg::ext_acc(prod_ff) + bed_pkg::ext_acc(z1_sel) + bed_pkg::ROUND_HALF;
      bx2 = bed_pkg::ext_acc(bx_ff) <<< 1;
      if (sec_ff == bed_pkg::SEC_HP) begin
         t1 = -bx2 - bed_pkg::ext_acc(prod_ff) + bed_pkg::ext_acc(z2_sel);
      end else begin
         t1 = bx2 - bed_pkg::ext_acc(prod_ff) + bed_pkg::ext_acc(z2_sel);
      end
      z1_new = bed_pkg::sat_state(t1);
      z2_new = bed_pkg::sat_state(bed_pkg::ext_acc(bx_ff) - bed_pkg::ext_acc(prod_ff));

      decim_m = (decim_ff == '0) ? bed_pkg::DECIM_W'(1) : decim_ff;
      emit    = ({1'b0, count_ff} + (bed_pkg::DECIM_W + 1)'(1)) >= {1'b0, decim_m};
   end

   always_comb begin
      state_in     = state_ff;
      sec_in       = sec_ff;
      a1_in        = a1_ff;
      a2_in        = a2_ff;
      z1_in        = z1_ff;
      z2_in        = z2_ff;
      decim_in     = decim_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      b0_in        = b0_ff;
      bx_in        = bx_ff;

      if (csr_valid) begin
         case (csr_index)
            bed_pkg::CSR_HP_A1: a1_in[0] = csr_data;
            bed_pkg::CSR_HP_A2: a2_in[0] = csr_data;
            bed_pkg::CSR_BL_A1: a1_in[1] = csr_data;
            bed_pkg::CSR_BL_A2: a2_in[1] = csr_data;
            bed_pkg::CSR_SM_A1: a1_in[2] = csr_data;
            bed_pkg::CSR_SM_A2: a2_in[2] = csr_data;
            bed_pkg::CSR_DECIM: decim_in = csr_data[bed_pkg::DECIM_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         bed_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               x_in     = req_tdata;
               sec_in   = bed_pkg::SEC_HP;
               state_in = bed_pkg::ST_COEF;
            end
         end
         bed_pkg::ST_COEF: begin
            b0_in    = bsum[bed_pkg::BSUM_W-1:2];
            state_in = bed_pkg::ST_MUL_BX;
         end
         bed_pkg::ST_MUL_BX: state_in = bed_pkg::ST_ACC;
         bed_pkg::ST_ACC: begin
            bx_in    = prod_ff;
            y_in     = bed_pkg::sat_sample(acc >>> bed_pkg::COEF_FRAC);
            state_in = bed_pkg::ST_MUL_A1;
         end
         bed_pkg::ST_MUL_A1: state_in = bed_pkg::ST_Z1;
         bed_pkg::ST_Z1: begin
            z1_in[si] = z1_new;
            state_in  = bed_pkg::ST_MUL_A2;
         end
         bed_pkg::ST_MUL_A2: state_in = bed_pkg::ST_Z2;
         bed_pkg::ST_Z2: begin
            z2_in[si] = z2_new;
            case (sec_ff)
               bed_pkg::SEC_HP: begin
                  x_in     = y_ff;
                  sec_in   = bed_pkg::SEC_BL;
                  state_in = bed_pkg::ST_COEF;
               end
               bed_pkg::SEC_BL: begin
                  x_in     = bed_pkg::rectify(y_ff);
                  sec_in   = bed_pkg::SEC_SM;
                  state_in = bed_pkg::ST_COEF;
               end
               default: begin
                  x_in     = y_ff;
                  state_in = bed_pkg::ST_DONE;
               end
            endcase
         end
         bed_pkg::ST_DONE: begin
            if (!emit) begin
               count_in = count_ff + bed_pkg::DECIM_W'(1);
               state_in = bed_pkg::ST_IDLE;
            end else if (!rsp_valid_ff || rsp_tready) begin
               count_in     = '0;
               rsp_valid_in = 1'b1;
               rsp_data_in  = x_ff;
               state_in     = bed_pkg::ST_IDLE;
            end
         end
         default: state_in = bed_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bed_pkg::ST_IDLE;
         sec_ff       <= bed_pkg::SEC_HP;
         decim_ff     <= bed_pkg::DECIM_W'(1);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            a1_ff[i] <= '0;
            a2_ff[i] <= '0;
            z1_ff[i] <= '0;
            z2_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         sec_ff       <= sec_in;
         decim_ff     <= decim_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         a1_ff        <= a1_in;
         a2_ff        <= a2_in;
         z1_ff        <= z1_in;
         z2_ff        <= z2_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      b0_ff       <= b0_in;
      prod_ff     <= prod_in;
      bx_ff       <= bx_in;
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("req_tready high right after an accepted beat");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == bed_pkg::ST_DONE))
      else $error("result beat raised outside the final step");

   a_done_last_section: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bed_pkg::ST_DONE) |-> (sec_ff == bed_pkg::SEC_SM))
      else $error("sequence finished before the envelope section");

   a_count_on_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff != bed_pkg::ST_DONE) |=> $stable(count_ff))
      else $error("decimation count moved outside the final step");

endmodule
`default_nettype wire

// ----- test/tb_bandpass_envelope_decimator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bandpass_envelope_decimator
// Streams samples through the envelope decimator under reset, extreme and
// random coefficient and decimation settings. A bit-true predictor of the
// highpass, lowpass, rectifier, envelope lowpass and decimator queues every
// envelope beat it expects, and the monitor checks the result stream in
// order. Both sides idle in random bursts, and the receiver stalls once for a
// long stretch so that the block backs up onto its input.
// ----------------------------------------------------------------------------
module tb_bandpass_envelope_decimator;
   import bed_pkg::*;

   localparam int HALF_PERIOD    = 5;
   localparam int RESET_CYCLES   = 7;
   localparam int SETTLE_CYCLES  = 50;
   localparam int LONG_HOLD      = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_PHASES  = 14;
   localparam int PHASE_ITEMS    = 102;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 3'd7;
   localparam longint Q_ONE = 64'sd1 <<< COEF_FRAC;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic [SAMPLE_W-1:0]    req_tdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [SAMPLE_W-1:0]    rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [COEF_W-1:0]      csr_data   = '0;

   // predictor state, indexed by section
   logic signed [COEF_W-1:0]  fb_a1 [3];
   logic signed [COEF_W-1:0]  fb_a2 [3];
   logic signed [STATE_W-1:0] dly_one [3];
   logic signed [STATE_W-1:0] dly_two [3];
   logic [DECIM_W-1:0]        decim_period;
   logic [DECIM_W-1:0]        decim_count;

   logic [SAMPLE_W-1:0] pending_samples [$];
   logic [SAMPLE_W-1:0] expected_envelopes [$];
   logic [SAMPLE_W-1:0] want_env;

   int  samples_queued = 0;
   int  samples_taken  = 0;
   int  fail_count     = 0;
   int  quiet_cycles   = 0;
   logic req_taken     = 1'b0;
   bit  gaps_on        = 1'b1;
   bit  hold_ask       = 1'b0;
   bit  hold_done      = 1'b0;
   int  tx_gap         = 0;
   int  rx_gap         = 0;
   int  hold_left      = 0;

   bandpass_envelope_decimator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   function automatic longint clamp_signed(longint v, int w);
      longint hi;
      hi = (64'sd1 <<< (w - 1)) - 1;
      if (v > hi) begin
         return hi;
      end else if (v < -hi - 1) begin
         return -hi - 1;
      end
      return v;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] biquad_step(sec_type sec,
         logic signed [SAMPLE_W-1:0] x, bit highpass);
      longint a1, a2, xs, b0, b1, acc, y;
      a1 = fb_a1[sec];
      a2 = fb_a2[sec];
      xs = x;
      if (highpass) begin
         b0 = (Q_ONE - a1 + a2) >>> 2;
         b1 = -2 * b0;
      end else begin
         b0 = (Q_ONE + a1 + a2) >>> 2;
         b1 = 2 * b0;
      end
      acc = b0 * xs + longint'(dly_one[sec]) + (64'sd1 <<< (COEF_FRAC - 1));
      y = clamp_signed(acc >>> COEF_FRAC, SAMPLE_W);
      dly_one[sec] = STATE_W'(clamp_signed(b1 * xs - a1 * y + longint'(dly_two[sec]),
                                           STATE_W));
      dly_two[sec] = STATE_W'(clamp_signed(b0 * xs - a2 * y, STATE_W));
      return SAMPLE_W'(y);
   endfunction

   function automatic void predict_envelope(logic [SAMPLE_W-1:0] raw);
      logic signed [SAMPLE_W-1:0] band;
      logic signed [SAMPLE_W-1:0] env;
      int period;
      band = biquad_step(SEC_HP, raw, 1'b1);
      band = biquad_step(SEC_BL, band, 1'b0);
      if (band == SAMPLE_MIN) begin
         band = SAMPLE_MAX;
      end else if (band < 0) begin
         band = -band;
      end
      env = biquad_step(SEC_SM, band, 1'b0);
      period = (decim_period == 0) ? 1 : int'(decim_period);
      if (int'(decim_count) + 1 >= period) begin
         decim_count = '0;
         expected_envelopes.push_back(env);
      end else begin
         decim_count = decim_count + 1'b1;
      end
   endfunction

   function automatic void apply_csr(logic [CSR_INDEX_W-1:0] idx, logic [COEF_W-1:0] data);
      case (idx)
         CSR_HP_A1: fb_a1[SEC_HP] = data;
         CSR_HP_A2: fb_a2[SEC_HP] = data;
         CSR_BL_A1: fb_a1[SEC_BL] = data;
         CSR_BL_A2: fb_a2[SEC_BL] = data;
         CSR_SM_A1: fb_a1[SEC_SM] = data;
         CSR_SM_A2: fb_a2[SEC_SM] = data;
         CSR_DECIM: decim_period = data[DECIM_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic void clear_predictor();
      for (int s = 0; s < 3; s++) begin
         fb_a1[s]   = '0;
         fb_a2[s]   = '0;
         dly_one[s] = '0;
         dly_two[s] = '0;
      end
      decim_period = 1;
      decim_count  = '0;
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample(int amp_shift);
      logic signed [SAMPLE_W-1:0] raw;
      int roll;
      raw  = SAMPLE_W'($urandom);
      roll = $urandom_range(0, 19);
      if (roll == 0) begin
         return SAMPLE_MIN;
      end else if (roll == 1) begin
         return SAMPLE_MAX;
      end else if (roll < 10) begin
         return raw;
      end
      return raw >>> amp_shift;
   endfunction

   // stable sections keep |a1| < 1 + a2 with 0 <= a2 < 0.95
   function automatic void pick_coefs(bit wild, output logic [COEF_W-1:0] a1,
         output logic [COEF_W-1:0] a2);
      longint p1, p2;
      if (wild) begin
         a1 = $urandom;
         a2 = $urandom;
      end else begin
         p2 = $urandom_range(0, 1020054732);
         p1 = $urandom_range(0, 32'(Q_ONE + p2 - 1));
         if ($urandom_range(0, 1) == 1) begin
            p1 = -p1;
         end
         a1 = COEF_W'(p1);
         a2 = COEF_W'(p2);
      end
   endfunction

   task automatic queue_sample(logic [SAMPLE_W-1:0] s);
      pending_samples.push_back(s);
      samples_queued++;
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, logic [COEF_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(logic [COEF_W-1:0] hp1, logic [COEF_W-1:0] hp2,
         logic [COEF_W-1:0] bl1, logic [COEF_W-1:0] bl2,
         logic [COEF_W-1:0] sm1, logic [COEF_W-1:0] sm2,
         logic [COEF_W-1:0] decim_word, bit spare);
      csr_write(CSR_HP_A1, hp1);
      csr_write(CSR_HP_A2, hp2);
      csr_write(CSR_BL_A1, bl1);
      csr_write(CSR_BL_A2, bl2);
      csr_write(CSR_SM_A1, sm1);
      csr_write(CSR_SM_A2, sm2);
      csr_write(CSR_DECIM, decim_word);
      if (spare) begin
         csr_write(CSR_SPARE, $urandom);
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (samples_taken != samples_queued || expected_envelopes.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // sample source
   always @(negedge clock) begin
      if (!reset) begin
         if (req_tvalid && !req_taken) begin
            // hold the offered beat
         end else if (tx_gap != 0) begin
            tx_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_samples.size() != 0 && gaps_on &&
                      $urandom_range(0, 11) == 0) begin
            tx_gap = $urandom_range(1, 17) - 1;
            req_tvalid <= 1'b0;
         end else if (pending_samples.size() != 0) begin
            req_tdata  <= pending_samples.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // envelope sink
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_ask && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            rsp_tready <= 1'b0;
         end else if (rx_gap != 0) begin
            rx_gap--;
            rsp_tready <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            rx_gap = $urandom_range(1, 17) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // monitor, predictor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         req_taken <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_envelopes.size() == 0) begin
               $error("envelope beat with none expected: actual %0d", $signed(rsp_tdata));
               fail_count++;
            end else begin
               want_env = expected_envelopes.pop_front();
               if (rsp_tdata !== want_env) begin
                  $error("envelope mismatch: expected %0d, actual %0d",
                         $signed(want_env), $signed(rsp_tdata));
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            apply_csr(csr_index, csr_data);
         end
         if (req_tvalid && req_tready) begin
            predict_envelope(req_tdata);
            samples_taken++;
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_bandpass_envelope_decimator NOT OK");
            $finish;
         end
      end
   end

   initial begin
      logic [COEF_W-1:0] c [6];
      logic [COEF_W-1:0] decim_word;
      int amp;
      int roll;
      int dec;

      clear_predictor();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset configuration, sample extremes and alternating bits
      queue_sample(16'h7FFF);
      queue_sample(16'h8000);
      queue_sample(16'h0000);
      queue_sample(16'hFFFF);
      queue_sample(16'h0001);
      queue_sample(16'h5555);
      queue_sample(16'hAAAA);
      wait_idle();

      // coefficient extremes drive the band to full negative scale, decimation zero
      configure(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 1'b1);
      repeat (4) queue_sample(16'h8000);
      repeat (2) queue_sample(16'h7FFF);
      wait_idle();

      // longest decimation, then lower it below the running count
      c[0] = -32'sd1932735283;
      c[1] = 32'sd869730877;
      c[2] = -32'sd1073741824;
      c[3] = 32'sd536870912;
      c[4] = -32'sd2040109466;
      c[5] = 32'sd969051586;
      configure(c[0], c[1], c[2], c[3], c[4], c[5], 32'h0000_FFFF, 1'b0);
      queue_sample(16'd12000);
      queue_sample(-16'sd12000);
      queue_sample(16'd30000);
      queue_sample(-16'sd30000);
      queue_sample(16'd777);
      wait_idle();
      configure(c[0], c[1], c[2], c[3], c[4], c[5], 32'hC3A5_0002, 1'b1);
      queue_sample(16'h00FF);
      queue_sample(16'hFFFF);
      queue_sample(16'h1234);
      wait_idle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         pick_coefs($urandom_range(0, 3) == 0, c[0], c[1]);
         pick_coefs($urandom_range(0, 3) == 0, c[2], c[3]);
         pick_coefs($urandom_range(0, 3) == 0, c[4], c[5]);
         roll = $urandom_range(0, 9);
         if (roll == 0) begin
            dec = 0;
         end else if (roll < 7) begin
            dec = $urandom_range(1, 4);
         end else if (roll < 9) begin
            dec = $urandom_range(5, 16);
         end else begin
            dec = $urandom_range(17, 60);
         end
         if (p == 2) begin
            dec = 1;
         end
         decim_word = $urandom;
         decim_word[DECIM_W-1:0] = DECIM_W'(dec);
         configure(c[0], c[1], c[2], c[3], c[4], c[5], decim_word,
                   $urandom_range(0, 2) == 0);
         gaps_on = (p < RANDOM_PHASES - 2);
         if (p == 2) begin
            hold_ask = 1'b1;
         end
         amp = $urandom_range(0, 12);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            queue_sample(pick_sample(amp));
         end
         wait_idle();
      end

      if (fail_count == 0) begin
         $display("tb_bandpass_envelope_decimator OK");
      end else begin
         $display("tb_bandpass_envelope_decimator NOT OK");
      end
      $finish;
   end

endmodule
